// ===== sv/tournament_tree_kway_merge_unit_assert.svh =====
// Assertion macros shared by the merge unit RTL.
`ifndef TOURNAMENT_TREE_KWAY_MERGE_UNIT_ASSERT_SVH
`define TOURNAMENT_TREE_KWAY_MERGE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock and quiet while reset is high.
`define TTKM_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and quiet while reset is high.
`define TTKM_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== sv/ttkm_pkg.sv =====
// Shared constants and types of the tournament tree merge unit.
package ttkm_pkg;

   localparam int RUN_COUNT_DEF = 8;
   localparam int KEY_BITS_DEF  = 64;

   localparam int OP_W      = 2;
   localparam int RUN_IDX_W = 3;
   localparam int KEY_W     = 64;
   localparam int ACT_W     = 4;
   localparam int ACT_MAX   = 15;
   localparam int ACT_RESET = 8;

   localparam int REQ_FIELDS_W = RUN_IDX_W + KEY_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = KEY_W + RUN_IDX_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_KEY     = 2'd0;
   localparam logic [OP_W-1:0] OP_END     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   typedef enum logic [2:0] {
      PHASE_FILL  = 3'b001,
      PHASE_MERGE = 3'b010,
      PHASE_DONE  = 3'b100
   } phase_type;

endpackage

// ===== sv/ttkm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttkm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/tournament_tree_kway_merge_unit.sv =====
// Top level of the tournament tree k-way merge unit.
//
//  Channel  Dir  Handshake              Payload
//  req_     in   req_tvalid/req_tready  tuser = operation, tdata = run_index, key
//  rsp_     out  rsp_tvalid/rsp_tready  tdata = winner_key, winner_run,
//                                       tlast = merge_done, tuser = order_error
//  csr_     in   csr_valid/csr_ready    csr_data = active_runs
//
// An item that completes the fill phase or refills the awaited run replays the
// E active runs, where E is the clamped active run count: the replay reads the
// head-key memory one entry per cycle through a single compare. Fill items that
// do not complete the fill, restarts and ignored codes give no result; refused
// items skip the replay. Reset is synchronous and needs no clearing pass.
// A stalled result sits in the output register while the next item is accepted.

module tournament_tree_kway_merge_unit #(
   parameter int RUN_COUNT = ttkm_pkg::RUN_COUNT_DEF,
   parameter int KEY_BITS  = ttkm_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata from bit 0: run_index (3), key (64), zero padding.
   input  logic [ttkm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: operation (2).
   input  logic [ttkm_pkg::OP_W-1:0]          req_tuser,
   // Result items.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata from bit 0: winner_key (64), winner_run (3), zero padding.
   output logic [ttkm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tlast: merge_done.
   output logic                               rsp_tlast,
   // tuser: order_error.
   output logic                               rsp_tuser,
   // Configuration write of active_runs.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ttkm_pkg::ACT_W-1:0]         csr_data
);

   localparam int ADDR_W    = $clog2(RUN_COUNT);
   localparam int KEY_W     = ttkm_pkg::KEY_W;
   localparam int RUN_IDX_W = ttkm_pkg::RUN_IDX_W;
   localparam int ACT_W     = ttkm_pkg::ACT_W;
   localparam int RSP_PAD_W = ttkm_pkg::RSP_TDATA_W - ttkm_pkg::RSP_FIELDS_W;
   localparam int EFF_MAX   = (RUN_COUNT < ttkm_pkg::ACT_MAX) ? RUN_COUNT : ttkm_pkg::ACT_MAX;
   localparam logic [ACT_W-1:0] EFF_MAX_V = ACT_W'(EFF_MAX);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Control state.
   state_type                state_ff, state_in;
   ttkm_pkg::phase_type      phase_ff, phase_in;
   logic [ACT_W-1:0]         act_ff, act_in;
   logic [ACT_W-1:0]         fill_cnt_ff, fill_cnt_in;
   logic [RUN_IDX_W-1:0]     awaited_ff, awaited_in;
   logic [RUN_COUNT-1:0]     head_valid_ff, head_valid_in;
   logic [ACT_W-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     best_found_ff, best_found_in;
   logic                     pend_err_ff, pend_err_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic                     rd_live_ff, rd_live_in;
   logic [ADDR_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [KEY_BITS-1:0]      best_key_ff, best_key_in;
   logic [ADDR_W-1:0]        best_run_ff, best_run_in;
   logic [ttkm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_user_ff, rsp_user_in;

   // Request decode.
   logic                     req_accept;
   logic [RUN_IDX_W-1:0]     req_run;
   logic [KEY_BITS-1:0]      req_key;
   logic [ADDR_W-1:0]        req_addr;
   logic                     run_in_range;
   logic                     run_expected;
   logic [ACT_W-1:0]         eff_act;

   // Head-key memory.
   logic                     ram_we;
   logic                     ram_re;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [KEY_BITS-1:0]      ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_run    = req_tdata[RUN_IDX_W-1:0];
   assign req_key    = KEY_BITS'(req_tdata[RUN_IDX_W +: KEY_W]);
   assign req_addr   = ADDR_W'(req_run);
   assign run_in_range = ({29'd0, req_run} < 32'(RUN_COUNT));

   // The register is read at every item; zero counts as one run and anything
   // above the tree size counts as the full tree.
   assign eff_act = (act_ff == '0) ? ACT_W'(1) :
                    ((act_ff > EFF_MAX_V) ? EFF_MAX_V : act_ff);

   // During fill the runs arrive in order; during merge only the run that
   // supplied the last winner may refill.
   always_comb begin
      if (phase_ff == ttkm_pkg::PHASE_FILL) begin
         run_expected = ({1'b0, req_run} == fill_cnt_ff);
      end else begin
         run_expected = (req_run == awaited_ff);
      end
   end

   assign ram_re      = (state_ff == ST_SCAN);
   assign ram_rd_addr = ADDR_W'(scan_cnt_ff);

   ttkm_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (RUN_COUNT)
   ) u_head_keys (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_addr),
      .wr_data (req_key),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      act_in        = csr_valid ? csr_data : act_ff;
      fill_cnt_in   = fill_cnt_ff;
      awaited_in    = awaited_ff;
      head_valid_in = head_valid_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_live_in    = rd_live_ff;
      rd_idx_in     = rd_idx_ff;
      best_found_in = best_found_ff;
      best_key_in   = best_key_ff;
      best_run_in   = best_run_ff;
      pend_err_in   = pend_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_user_in   = rsp_user_ff;
      ram_we        = 1'b0;

      // Compare stage of the replay: the key read last cycle meets the running
      // minimum. Scanning upward with a less-or-equal test hands ties to the
      // higher-numbered run, which is what the tree does at every node.
      if (rd_vld_ff && rd_live_ff) begin
         if (!best_found_ff || (ram_rd_data <= best_key_ff)) begin
            best_found_in = 1'b1;
            best_key_in   = ram_rd_data;
            best_run_in   = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  ttkm_pkg::OP_KEY, ttkm_pkg::OP_END: begin
                     if ((phase_ff == ttkm_pkg::PHASE_DONE) || !run_expected ||
                         !run_in_range) begin
                        pend_err_in = 1'b1;
                        state_in    = ST_EMIT;
                     end else begin
                        ram_we                  = (req_tuser == ttkm_pkg::OP_KEY);
                        head_valid_in[req_addr] = (req_tuser == ttkm_pkg::OP_KEY);
                        pend_err_in             = 1'b0;
                        best_found_in           = 1'b0;
                        scan_cnt_in             = '0;
                        state_in                = ST_SCAN;
                        if (phase_ff == ttkm_pkg::PHASE_FILL) begin
                           fill_cnt_in = fill_cnt_ff + ACT_W'(1);
                           // More runs still owe their first key.
                           if (fill_cnt_in < eff_act) begin
                              state_in = ST_IDLE;
                           end
                        end
                     end
                  end
                  ttkm_pkg::OP_RESTART: begin
                     head_valid_in = '0;
                     fill_cnt_in   = '0;
                     awaited_in    = '0;
                     phase_in      = ttkm_pkg::PHASE_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one head-key read per cycle over the active runs.
            rd_vld_in  = 1'b1;
            rd_live_in = head_valid_ff[ram_rd_addr];
            rd_idx_in  = ram_rd_addr;
            if (scan_cnt_ff == (eff_act - ACT_W'(1))) begin
               state_in = ST_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + ACT_W'(1);
            end
         end
         ST_DRAIN: begin
            // The last read is compared at this edge.
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (pend_err_ff) begin
                  rsp_data_in = '0;
                  rsp_last_in = 1'b0;
                  rsp_user_in = 1'b1;
               end else if (best_found_ff) begin
                  rsp_data_in = {{RSP_PAD_W{1'b0}}, RUN_IDX_W'(best_run_ff),
                                 KEY_W'(best_key_ff)};
                  rsp_last_in = 1'b0;
                  rsp_user_in = 1'b0;
                  phase_in    = ttkm_pkg::PHASE_MERGE;
                  awaited_in  = RUN_IDX_W'(best_run_ff);
               end else begin
                  // Every active head is empty: one done item, then refuse until restart.
                  rsp_data_in = '0;
                  rsp_last_in = 1'b1;
                  rsp_user_in = 1'b0;
                  phase_in    = ttkm_pkg::PHASE_DONE;
                  awaited_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= ttkm_pkg::PHASE_FILL;
         act_ff        <= ACT_W'(ttkm_pkg::ACT_RESET);
         fill_cnt_ff   <= '0;
         awaited_ff    <= '0;
         head_valid_ff <= '0;
         scan_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         pend_err_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         act_ff        <= act_in;
         fill_cnt_ff   <= fill_cnt_in;
         awaited_ff    <= awaited_in;
         head_valid_ff <= head_valid_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         pend_err_ff   <= pend_err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_live_ff  <= rd_live_in;
      rd_idx_ff   <= rd_idx_in;
      best_key_ff <= best_key_in;
      best_run_ff <= best_run_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

`include "tournament_tree_kway_merge_unit_assert.svh"

   // A memory read in flight belongs to a replay.
   `TTKM_ASSERT_IMPLY(a_read_in_replay, rd_vld_ff, (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), "head-key read outside a replay")

   // Between items in the merge phase the awaited run still holds a live head.
   `TTKM_ASSERT_IMPLY(a_awaited_live, (state_ff == ST_IDLE) && (phase_ff == ttkm_pkg::PHASE_MERGE), head_valid_ff[ADDR_W'(awaited_ff)], "awaited run has no live head")

   // A key or end mark after the merge is done turns into a refusal.
   `TTKM_ASSERT_NEXT(a_done_refuses, req_accept && (phase_ff == ttkm_pkg::PHASE_DONE) && ((req_tuser == ttkm_pkg::OP_KEY) || (req_tuser == ttkm_pkg::OP_END)), (state_ff == ST_EMIT) && pend_err_ff, "input after done not refused")

endmodule

// ===== verif/tournament_tree_kway_merge_unit_tb.sv =====
// Self-checking testbench for the tournament tree k-way merge unit.
module tournament_tree_kway_merge_unit_tb;
   import ttkm_pkg::*;

   // Operation code 3 is unused; the unit drops such items without a result.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_ITEMS  = 60;
   // The settle wait must outlast the slowest accepted item, a full replay.
   // A fill item or a restart gives no result, so the settle wait passes before
   // a register write or the end of the run.
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 500000;

   // One input item as it travels on the request channel.
   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [RUN_IDX_W-1:0] run;
      logic [KEY_W-1:0]     key;
   } merge_item_type;

   // One expected result item.
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [RUN_IDX_W-1:0] run;
      logic                 done;
      logic                 err;
   } merge_result_type;

   // The predictor's copy of the unit: heads, fill position, phase and register.
   typedef struct packed {
      logic [7:0][KEY_W-1:0] keys;
      logic [7:0]            valid;
      logic [3:0]            fill_cnt;
      phase_type             phase;
      logic [2:0]            awaited;
      logic [ACT_W-1:0]      active;
   } merge_state_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = OP_KEY;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ACT_W-1:0]       csr_data = '0;

   tournament_tree_kway_merge_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Items waiting to be driven, and the results the accepted items must give.
   merge_item_type   pending_items[$];
   merge_result_type expected_winners[$];

   // plan_state runs ahead as the stimulus is written, so that well-formed
   // sequences know which run the unit waits for; accepted_state follows the
   // handshakes and produces the expectations.
   merge_state_type plan_state;
   merge_state_type accepted_state;

   int  mismatches = 0;
   int  cycles = 0;
   int  queued_items = 0;
   int  accepted_items = 0;
   int  checked_results = 0;
   int  done_results = 0;
   int  refused_results = 0;
   int  settings_used = 0;
   bit  steady = 1'b0;

   // Wait drawn for each item; in a steady stretch neither side idles.
   function automatic int draw_wait();
      if (steady) return 0;
      return $urandom_range(0, 15);
   endfunction

   // Runs in use after the unit's clamping: 0 counts as 1, above 8 as 8.
   function automatic int runs_in_use(logic [ACT_W-1:0] a);
      if (a == 0) return 1;
      if (a > RUN_COUNT_DEF) return RUN_COUNT_DEF;
      return int'(a);
   endfunction

   function automatic merge_state_type cleared_merge(logic [ACT_W-1:0] a);
      merge_state_type s;
      s = '0;
      s.phase = PHASE_FILL;
      s.active = a;
      return s;
   endfunction

   // Plays the tournament bottom up over eight leaves. An empty left entrant
   // loses, then an empty right one; a strictly smaller left key wins, and
   // otherwise the right one does, so ties favor the higher run.
   function automatic logic [2:0] tournament_root(merge_state_type s, int used);
      logic [2:0] winner [0:14];
      logic [2:0] l;
      logic [2:0] r;
      bit         l_live;
      bit         r_live;
      for (int c = 7; c < 15; c++) winner[c] = 3'(c - 7);
      for (int i = 6; i >= 0; i--) begin
         l = winner[2*i+1];
         r = winner[2*i+2];
         l_live = (int'(l) < used) && s.valid[l];
         r_live = (int'(r) < used) && s.valid[r];
         if (!l_live) winner[i] = r;
         else if (!r_live) winner[i] = l;
         else if (s.keys[l] < s.keys[r]) winner[i] = l;
         else winner[i] = r;
      end
      return winner[0];
   endfunction

   // Applies one item to a merge state; returns 1 when the item gives a result.
   function automatic bit merge_step(inout merge_state_type s, input merge_item_type it,
                                     output merge_result_type res);
      int         used;
      logic [3:0] wanted;
      logic [2:0] root;
      res = '0;
      used = runs_in_use(s.active);
      if (it.op == OP_UNUSED) return 1'b0;
      if (it.op == OP_RESTART) begin
         s = cleared_merge(s.active);
         return 1'b0;
      end
      // Once every run is exhausted, keys and end marks are refused.
      if (s.phase == PHASE_DONE) begin
         res.err = 1'b1;
         return 1'b1;
      end
      wanted = (s.phase == PHASE_FILL) ? s.fill_cnt : {1'b0, s.awaited};
      // An item for any run but the awaited one is refused and changes nothing.
      if ({1'b0, it.run} != wanted) begin
         res.err = 1'b1;
         return 1'b1;
      end
      if (it.op == OP_KEY) begin
         s.keys[it.run] = it.key;
         s.valid[it.run] = 1'b1;
      end else begin
         s.valid[it.run] = 1'b0;
      end
      // The fill phase ends once the count reaches the runs in use; a count
      // already past a lowered register ends it on the next fill item too.
      if (s.phase == PHASE_FILL) begin
         s.fill_cnt = s.fill_cnt + 4'd1;
         if (int'(s.fill_cnt) < used) return 1'b0;
      end
      root = tournament_root(s, used);
      if ((int'(root) < used) && s.valid[root]) begin
         s.phase = PHASE_MERGE;
         s.awaited = root;
         res.key = s.keys[root];
         res.run = root;
      end else begin
         s.phase = PHASE_DONE;
         s.awaited = 3'd0;
         res.done = 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [KEY_W-1:0] got,
                                input logic [KEY_W-1:0] want);
      $display("mismatch in %s at result %0d: got %h, expected %h",
               what, checked_results, got, want);
      mismatches++;
   endtask

   // Every item goes through here, so the planning copy sees the same order
   // of items as the unit will.
   task automatic queue_item(input logic [OP_W-1:0] op, input logic [2:0] run,
                             input logic [KEY_W-1:0] key);
      merge_item_type   it;
      merge_result_type ignored;
      it.op = op;
      it.run = run;
      it.key = key;
      pending_items.insert(pending_items.size(), it);
      void'(merge_step(plan_state, it, ignored));
      queued_items++;
   endtask

   // The sender holds off until everything it sent has produced its result,
   // then lets the slowest possible item finish.
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_winners.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes active_runs while the unit is idle and updates both copies.
   task automatic set_active_runs(input logic [ACT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      accepted_state.active = value;
      plan_state = accepted_state;
      settings_used++;
   endtask

   // One merge with sorted runs of zero to five keys each. The fill order and
   // each refill follow the planning copy; now and then a random item is
   // slipped in, which may be refused, ignored, restart the merge, or land.
   task automatic one_merge();
      logic [KEY_W-1:0] run_keys [0:7][0:4];
      int               run_len [0:7];
      int               run_pos [0:7];
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] step;
      logic [2:0]       target;
      logic [OP_W-1:0]  op;
      int               budget;
      for (int r = 0; r < 8; r++) begin
         run_len[r] = $urandom_range(0, 5);
         run_pos[r] = 0;
         k = {$urandom, $urandom} >> $urandom_range(0, 63);
         for (int j = 0; j < 5; j++) begin
            run_keys[r][j] = k;
            // Repeated keys are common so that ties between runs happen.
            step = ($urandom_range(0, 2) == 0) ? '0 : (KEY_W'($urandom) >> $urandom_range(0, 31));
            k = (k + step < k) ? {KEY_W{1'b1}} : k + step;
         end
      end
      queue_item(OP_RESTART, 3'($urandom), {$urandom, $urandom});
      budget = 0;
      while (plan_state.phase != PHASE_DONE && budget < 60) begin
         budget++;
         if ($urandom_range(0, 19) == 0) begin
            op = 2'($urandom);
            queue_item(op, 3'($urandom), {$urandom, $urandom});
            if (op == OP_RESTART) return;
         end else begin
            target = (plan_state.phase == PHASE_FILL) ? plan_state.fill_cnt[2:0]
                                                      : plan_state.awaited;
            if (run_pos[target] < run_len[target]) begin
               queue_item(OP_KEY, target, run_keys[target][run_pos[target]]);
               run_pos[target]++;
            end else begin
               queue_item(OP_END, target, {$urandom, $urandom});
            end
         end
      end
      // Sometimes feed one more item after the merge has finished.
      if ($urandom_range(0, 1) == 0)
         queue_item($urandom_range(0, 1) ? OP_KEY : OP_END, 3'($urandom), {$urandom, $urandom});
   endtask

   // Driver: presents the queued items in order. After each item is handed
   // out a wait is drawn with draw_wait and spent before the next one.
   int               send_gap = 0;
   merge_item_type   next_item;
   merge_result_type next_result;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            next_item.op = req_tuser;
            next_item.run = req_tdata[RUN_IDX_W-1:0];
            next_item.key = req_tdata[RUN_IDX_W +: KEY_W];
            if (merge_step(accepted_state, next_item, next_result))
               expected_winners.insert(expected_winners.size(), next_result);
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               next_item = pending_items.pop_front();
               req_tuser <= next_item.op;
               req_tdata <= {{(REQ_TDATA_W-REQ_FIELDS_W){1'b0}}, next_item.key, next_item.run};
               req_tvalid <= 1'b1;
               send_gap = draw_wait();
            end
         end
      end
   end

   // Monitor: takes result items, stalling a drawn number of cycles after
   // each one, and compares every field with the oldest expectation.
   int               stall_left = 0;
   merge_result_type oldest;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_winners.size() == 0) begin
               flag_mismatch("unexpected result", rsp_tdata[KEY_W-1:0], '0);
            end else begin
               oldest = expected_winners.pop_front();
               if (rsp_tdata[KEY_W-1:0] !== oldest.key)
                  flag_mismatch("winner_key", rsp_tdata[KEY_W-1:0], oldest.key);
               if (rsp_tdata[KEY_W +: RUN_IDX_W] !== oldest.run)
                  flag_mismatch("winner_run", KEY_W'(rsp_tdata[KEY_W +: RUN_IDX_W]),
                                KEY_W'(oldest.run));
               if (rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W] !== '0)
                  flag_mismatch("tdata padding",
                                KEY_W'(rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W]), '0);
               if (rsp_tlast !== oldest.done)
                  flag_mismatch("merge_done", KEY_W'(rsp_tlast), KEY_W'(oldest.done));
               if (rsp_tuser !== oldest.err)
                  flag_mismatch("order_error", KEY_W'(rsp_tuser), KEY_W'(oldest.err));
               if (oldest.done) done_results++;
               if (oldest.err) refused_results++;
            end
            checked_results++;
            stall_left = draw_wait();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycles, expected_winners.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Stimulus: directed corners first, then random merges under several
   // register settings, the extremes first.
   logic [ACT_W-1:0] corner_settings [0:3];
   int               phase_no;
   int               phase_start;
   bit               paused;

   initial begin
      corner_settings[0] = 4'd1;
      corner_settings[1] = 4'd8;
      corner_settings[2] = 4'd0;
      corner_settings[3] = ACT_W'(ACT_MAX);
      accepted_state = cleared_merge(ACT_W'(ACT_RESET));
      plan_state = accepted_state;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fill with the register at its reset value: a refused wrong run, an
      // unused code, the key extremes, a tie at zero between runs 1 and 2
      // that run 2 must win, and end marks for the upper runs.
      queue_item(OP_END, 3'd1, '0);
      queue_item(OP_UNUSED, 3'd0, {KEY_W{1'b1}});
      queue_item(OP_KEY, 3'd0, {KEY_W{1'b1}});
      queue_item(OP_KEY, 3'd1, '0);
      queue_item(OP_KEY, 3'd2, '0);
      queue_item(OP_KEY, 3'd3, 64'd5);
      for (int r = 4; r < 8; r++) queue_item(OP_END, 3'(r), '0);
      // Merge phase: a refill for the wrong run, then the awaited refills,
      // then a restart in the middle of the merge.
      queue_item(OP_KEY, 3'd0, 64'd1);
      queue_item(OP_END, 3'd2, '0);
      queue_item(OP_KEY, 3'd1, 64'h8000_0000_0000_0000);
      queue_item(OP_RESTART, 3'd7, '0);

      // Zero counts as one run: one key, its end mark, then a key after done.
      set_active_runs(4'd0);
      queue_item(OP_KEY, 3'd0, 64'h0123_4567_89ab_cdef);
      queue_item(OP_END, 3'd0, '0);
      queue_item(OP_KEY, 3'd0, 64'd9);

      // Register lowered in the middle of the fill: with three runs filled
      // and the limit dropped to two, the next fill item ends the fill and
      // run 2 no longer takes part.
      set_active_runs(ACT_W'(ACT_MAX));
      queue_item(OP_RESTART, 3'd0, '0);
      queue_item(OP_KEY, 3'd0, 64'd300);
      queue_item(OP_KEY, 3'd1, 64'd200);
      queue_item(OP_KEY, 3'd2, 64'd100);
      set_active_runs(4'd2);
      queue_item(OP_END, 3'd3, '0);
      queue_item(OP_END, 3'd1, '0);

      phase_no = 0;
      phase_start = queued_items;
      while (queued_items - phase_start < RANDOM_ITEMS) begin
         if (phase_no < 4) set_active_runs(corner_settings[phase_no]);
         else set_active_runs(ACT_W'($urandom_range(0, ACT_MAX)));
         steady = ($urandom_range(0, 3) == 0);
         paused = 1'b0;
         for (int n = queued_items; queued_items - n < PHASE_ITEMS; ) begin
            one_merge();
            // Once per setting the sender stops until every result is in.
            if (!paused && queued_items - n >= PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
         phase_no++;
      end

      wait_drained();
      $display("Ran %0d items under %0d register settings: %0d results checked,",
               accepted_items, settings_used, checked_results);
      $display("including %0d refused items and %0d finished merges; %0d mismatches.",
               refused_results, done_results, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
